/* hw/rtl/tsdg_pkg.sv */
// ----------------------------------------------------------------------------
// tsdg_pkg: shared types, constants and stage logic
// Widths, the pipeline item record and the per-stage step of the torus
// distance/gradient cell chain.
// ----------------------------------------------------------------------------
package tsdg_pkg;

   localparam int CW = 32;               // coordinate width
   localparam int FB = 16;               // fraction bits

   localparam int RT_W  = CW + 1;        // square root result width
   localparam int K     = RT_W;          // root bits = sqrt steps
   localparam int RAD_W = 2 * K;         // radicand width
   localparam int SQ_W  = 2 * RT_W;      // widest square
   localparam int REM_W = K + 3;         // sqrt partial remainder
   localparam int DR_W  = CW + 2;        // divider partial remainder
   localparam int QT_W  = FB + 1;        // ratio width, up to 1.0
   localparam int EW    = ((CW > FB) ? CW : FB) + 2;

   // stage map
   localparam int S_DIFF  = 0;
   localparam int S_SQ1   = 1;
   localparam int S_SUM1  = 2;
   localparam int S_R1    = 3;
   localparam int S_Q     = S_R1 + K;
   localparam int S_SQ2   = S_Q + 1;
   localparam int S_SUM2  = S_Q + 2;
   localparam int S_R2    = S_Q + 3;
   localparam int S_DIV   = S_R2 + K;
   localparam int S_MUL   = S_DIV + FB + 1;
   localparam int S_FIN   = S_MUL + 1;
   localparam int N_CELLS = S_FIN + 1;
   localparam int ST_W    = $clog2(N_CELLS);

   // config port
   localparam int CSR_DW  = (CW > 32) ? 64 : 32;
   localparam int ADR_LSB = (CW > 32) ? 3 : 2;
   localparam int PA_W    = ADR_LSB + 3;

   typedef enum logic [2:0] {
      REG_MAJOR  = 3'd0,
      REG_MINOR  = 3'd1,
      REG_CX     = 3'd2,
      REG_CY     = 3'd3,
      REG_CZ     = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [CW-2:0] major;
      logic [CW-2:0] minor;
      logic [CW-1:0] cx;
      logic [CW-1:0] cy;
      logic [CW-1:0] cz;
   } cfg_type;

   typedef struct packed {
      logic                      nx, ny, nz;
      logic [CW-1:0]             ax, ay, az;   // raw point on entry
      logic [SQ_W-1:0]           sq_a;
      logic [2*CW-1:0]           sq_b;
      logic [RAD_W-1:0]          rad;
      logic [REM_W-1:0]          rem;
      logic [RT_W-1:0]           root;
      logic [RT_W-1:0]           rho;
      logic                      qneg;
      logic [RT_W-1:0]           qm;
      logic [RT_W-1:0]           s;
      logic [3:0][DR_W-1:0]      dv_rem;
      logic [3:0][QT_W-1:0]      dv_quo;
      logic                      degen;
      logic [QT_W-1:0]           mx, mz;
      logic [CW-1:0]             sdist, gx, gy, gz;
   } pipe_type;

   function automatic logic [CW-1:0] sat(input logic signed [EW-1:0] e);
      logic signed [EW-1:0] hi;
      logic signed [EW-1:0] lo;
      hi = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
      lo = ~hi;
      if (e > hi)
         return hi[CW-1:0];
      else if (e < lo)
         return lo[CW-1:0];
      else
         return e[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] signed_grad(input logic neg,
                                                 input logic [QT_W-1:0] m);
      logic signed [EW-1:0] e;
      e = EW'(m);
      if (neg)
         e = -e;
      return sat(e);
   endfunction

   function automatic pipe_type cell_step(input logic [ST_W-1:0] stg,
                                          input cfg_type cfg,
                                          input pipe_type d);
      pipe_type             o;
      logic [CW:0]          dx, dy, dz;
      logic [2*CW-1:0]      pa, pb;
      logic [SQ_W-1:0]      pq;
      logic [REM_W-1:0]     t_rem, trial;
      logic [CW+1:0]        qd, dd;
      logic [DR_W-1:0]      t, den;
      logic [RT_W-1:0]      num, dv;
      logic [2*QT_W-1:0]    px, pz;
      o = d;
      if (stg == ST_W'(S_DIFF)) begin
         dx = {d.ax[CW-1], d.ax} - {cfg.cx[CW-1], cfg.cx};
         dy = {d.ay[CW-1], d.ay} - {cfg.cy[CW-1], cfg.cy};
         dz = {d.az[CW-1], d.az} - {cfg.cz[CW-1], cfg.cz};
         o.nx = dx[CW];
         o.ny = dy[CW];
         o.nz = dz[CW];
         o.ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
         o.ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];
         o.az = dz[CW] ? CW'(-dz) : dz[CW-1:0];
      end else if (stg == ST_W'(S_SQ1)) begin
         pa = d.ax * d.ax;
         pb = d.az * d.az;
         o.sq_a = SQ_W'(pa);
         o.sq_b = pb;
      end else if (stg == ST_W'(S_SUM1) || stg == ST_W'(S_SUM2)) begin
         o.rad  = RAD_W'(d.sq_a) + RAD_W'(d.sq_b);
         o.rem  = '0;
         o.root = '0;
      end else if ((stg >= ST_W'(S_R1) && stg < ST_W'(S_Q)) ||
                   (stg >= ST_W'(S_R2) && stg < ST_W'(S_DIV))) begin
         // one root bit per cell
         t_rem = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
         trial = {1'b0, d.root, 2'b01};
         if (t_rem >= trial) begin
            o.rem  = t_rem - trial;
            o.root = {d.root[RT_W-2:0], 1'b1};
         end else begin
            o.rem  = t_rem;
            o.root = {d.root[RT_W-2:0], 1'b0};
         end
         o.rad = {d.rad[RAD_W-3:0], 2'b00};
      end else if (stg == ST_W'(S_Q)) begin
         o.rho  = d.root;
         qd     = {1'b0, d.root} - {3'b000, cfg.major};
         o.qneg = qd[CW+1];
         o.qm   = qd[CW+1] ? RT_W'(-qd) : qd[RT_W-1:0];
      end else if (stg == ST_W'(S_SQ2)) begin
         pq = d.qm * d.qm;
         pb = d.ay * d.ay;
         o.sq_a = pq;
         o.sq_b = pb;
      end else if (stg == ST_W'(S_DIV)) begin
         o.s     = d.root;
         o.degen = (d.rho == '0) || (d.root == '0);
         for (int i = 0; i < 4; i++) begin
            case (i)
               0:       begin num = d.qm;         dv = d.root; end
               1:       begin num = RT_W'(d.ax);  dv = d.rho;  end
               2:       begin num = RT_W'(d.az);  dv = d.rho;  end
               default: begin num = RT_W'(d.ay);  dv = d.root; end
            endcase
            t   = DR_W'(num);
            den = DR_W'(dv);
            if (t >= den) begin
               o.dv_rem[i] = t - den;
               o.dv_quo[i] = QT_W'(1);
            end else begin
               o.dv_rem[i] = t;
               o.dv_quo[i] = '0;
            end
         end
      end else if (stg > ST_W'(S_DIV) && stg < ST_W'(S_MUL)) begin
         // one quotient bit per cell in each of the four ratios
         for (int i = 0; i < 4; i++) begin
            dv  = (i == 1 || i == 2) ? d.rho : d.s;
            den = DR_W'(dv);
            t   = {d.dv_rem[i][DR_W-2:0], 1'b0};
            if (t >= den) begin
               o.dv_rem[i] = t - den;
               o.dv_quo[i] = {d.dv_quo[i][QT_W-2:0], 1'b1};
            end else begin
               o.dv_rem[i] = t;
               o.dv_quo[i] = {d.dv_quo[i][QT_W-2:0], 1'b0};
            end
         end
      end else if (stg == ST_W'(S_MUL)) begin
         px   = d.dv_quo[0] * d.dv_quo[1];
         pz   = d.dv_quo[0] * d.dv_quo[2];
         o.mx = px[FB +: QT_W];
         o.mz = pz[FB +: QT_W];
      end else if (stg == ST_W'(S_FIN)) begin
         dd      = {1'b0, d.s} - {3'b000, cfg.minor};
         o.sdist = sat(EW'($signed(dd)));
         if (d.degen) begin
            o.gx = '0;
            o.gy = '0;
            o.gz = '0;
         end else begin
            o.gx = signed_grad(d.nx ^ d.qneg, d.mx);
            o.gy = signed_grad(d.ny, d.dv_quo[3]);
            o.gz = signed_grad(d.nz ^ d.qneg, d.mz);
         end
      end
      return o;
   endfunction

endpackage

/* hw/rtl/torus_signed_distance_gradient.sv */
// ----------------------------------------------------------------------------
// torus_signed_distance_gradient: torus distance and gradient engine
// Signed distance from a Q16.16 point to a y-axis torus plus its gradient,
// computed in a chain of identical cells, one point per clock while rsp_tready is high.
// ----------------------------------------------------------------------------
//  channel | ports  | item contents (low bits first)
//  --------+--------+-----------------------------------------------
//  input   | req_*  | tdata: point_x, point_y, point_z
//  result  | rsp_*  | tdata: distance, grad_x, grad_y, grad_z
//          |        | tuser: degenerate
//  config  | csr_*  | major_radius, minor_radius, center_x/y/z
//
//  One item per clock sustained while rsp_tready stays high. The chain
//  length is set by the two bit-serial square roots (one root bit per
//  cell, 33 at Q16.16) and four ratio dividers (one quotient bit per cell).
//  Reset is synchronous and empties the chain; registers go to R=1.0,
//  r=0.25, center at the origin. A stall on rsp_tready backs up cell by
//  cell; empty cells keep taking items until the chain is full.
// ----------------------------------------------------------------------------
module torus_signed_distance_gradient
   import tsdg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [3*CW-1:0]   req_tdata,   // point_x, point_y, point_z
   // result items
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [4*CW-1:0]   rsp_tdata,   // distance, grad_x, grad_y, grad_z
   output logic              rsp_tuser,   // degenerate
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [PA_W-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type  cfg;
   pipe_type in_item;
   pipe_type out_item;

   logic     chain_valid [N_CELLS+1];
   logic     chain_ready [N_CELLS+1];
   pipe_type chain_data  [N_CELLS+1];

   assign csr_pready = 1'b1;

   tsdg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // raw coordinates ride in the magnitude slots until the first cell
   always_comb begin
      in_item    = '0;
      in_item.ax = req_tdata[0*CW +: CW];
      in_item.ay = req_tdata[1*CW +: CW];
      in_item.az = req_tdata[2*CW +: CW];
   end

   assign chain_valid[0]       = req_tvalid;
   assign chain_data[0]        = in_item;
   assign req_tready           = chain_ready[0];
   assign chain_ready[N_CELLS] = rsp_tready;

   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      tsdg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .stage_id (ST_W'(i)),
         .cfg      (cfg),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   // last cell is the output register
   assign out_item   = chain_data[N_CELLS];
   assign rsp_tvalid = chain_valid[N_CELLS];
   assign rsp_tdata  = {out_item.gz, out_item.gy, out_item.gx, out_item.sdist};
   assign rsp_tuser  = out_item.degen;

endmodule

/* hw/rtl/tsdg_cell.sv */
// ----------------------------------------------------------------------------
// tsdg_cell: one cell of the processing chain
// Holds one item, applies its stage step and hands it on; while empty it
// takes a new item even while the cell downstream stalls.
// ----------------------------------------------------------------------------
module tsdg_cell
   import tsdg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [ST_W-1:0]   stage_id,
   input  cfg_type           cfg,
   input  logic              up_valid,
   output logic              up_ready,
   input  pipe_type          up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output pipe_type          dn_data
);

   logic     valid_ff;
   pipe_type data_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= cell_step(stage_id, cfg, up_data);
      end
   end

endmodule

/* hw/rtl/tsdg_csr.sv */
// ----------------------------------------------------------------------------
// tsdg_csr: configuration registers
// Torus radii and center behind a simple APB-style port.
// ----------------------------------------------------------------------------
module tsdg_csr
   import tsdg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PA_W-1:0]   paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   logic        wr_en;
   reg_idx_type idx;

   assign idx   = reg_idx_type'(paddr[PA_W-1:ADR_LSB]);
   assign wr_en = psel && penable && pwrite;
   assign cfg   = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.major <= (CW-1)'(1) << FB;
         cfg_ff.minor <= (CW-1)'(1) << (FB - 2);
         cfg_ff.cx    <= '0;
         cfg_ff.cy    <= '0;
         cfg_ff.cz    <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_MAJOR: cfg_ff.major <= pwdata[CW-2:0];
            REG_MINOR: cfg_ff.minor <= pwdata[CW-2:0];
            REG_CX:    cfg_ff.cx    <= pwdata[CW-1:0];
            REG_CY:    cfg_ff.cy    <= pwdata[CW-1:0];
            REG_CZ:    cfg_ff.cz    <= pwdata[CW-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MAJOR: prdata = CSR_DW'(cfg_ff.major);
         REG_MINOR: prdata = CSR_DW'(cfg_ff.minor);
         REG_CX:    prdata = CSR_DW'(cfg_ff.cx);
         REG_CY:    prdata = CSR_DW'(cfg_ff.cy);
         REG_CZ:    prdata = CSR_DW'(cfg_ff.cz);
         default:   prdata = '0;
      endcase
   end

endmodule
